// ===== rtl/prfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the pulse flow rate meter.
// No dependencies; imported by every module of the block.
package prfm_pkg;

	// Default depth of the request queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Field and state widths
	localparam int TIME_W     = 32;
	localparam int TALLY_W    = 32;
	localparam int MIN_W      = 16;
	localparam int K_W        = 10;
	localparam int RATE_W     = 24;
	localparam int VOL_W      = 48;
	localparam int K60_W      = 16;
	localparam int VOLMS_W    = 42;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Divider widths: pulses * 256e6 < 2^60, 60 * k * elapsed < 2^48
	localparam int NUM_W = 60;
	localparam int DEN_W = 48;
	localparam int CNT_W = 6;

	// Scale constants
	localparam logic [27:0]    RATE_NUM = 28'd256000000;
	localparam logic [9:0]     VOL_MUL  = 10'd1000;
	localparam logic [5:0]     PER_MIN  = 6'd60;

	// Register reset values
	localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 16'd200;
	localparam logic [K_W-1:0]   K_RST            = 10'd38;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_LPM = 1'b1;

	// Request kinds
	localparam logic KIND_PULSE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Back-end sequencer states
	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
	localparam logic [STATE_W-1:0] ST_MUL  = 3'd1;
	localparam logic [STATE_W-1:0] ST_DEN  = 3'd2;
	localparam logic [STATE_W-1:0] ST_DIV  = 3'd3;
	localparam logic [STATE_W-1:0] ST_EMIT = 3'd4;

	typedef struct packed {
		logic [MIN_W-1:0] min_interval_ms;
		logic [K_W-1:0]   pulses_per_lpm;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic               div_done;
		logic               load_out;
	} back_status_t;

endpackage

// ===== rtl/prfm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on prfm_pkg.
module prfm_front import prfm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              mode,
	input  logic [TIME_W-1:0] now_ms,
	output logic              q_valid,
	output item_t             q_item,
	input  logic              q_pop
);

	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);

	item_t              slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               push;
	item_t              new_item;

	// Classify the incoming request
	always_comb begin
		new_item.kind   = (mode == 1'b1) ? KIND_READ : KIND_PULSE;
		new_item.now_ms = now_ms;
	end

	assign item_stall = (count_q == COUNT_W'(DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign q_item     = slots_q[rd_ptr_q];

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/prfm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on prfm_pkg.
module prfm_div import prfm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// Shift in the next numerator bit and try the subtraction
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	assign done = done_q;
	assign quo  = quo_q;

	// Hold operands and step the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// Count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/prfm_back.sv =====
`timescale 1ns / 1ps
// Back end: pulse tally, interval check, rate and volume computation, result register.
// Depends on prfm_pkg and prfm_div.
module prfm_back import prfm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               updated,
	output logic [RATE_W-1:0]  rate_q8,
	output logic [VOL_W-1:0]   volume_q16,
	output back_status_t       status
);

	logic [STATE_W-1:0] state_q;
	logic [TALLY_W-1:0] tally_q;
	logic [TIME_W-1:0]  last_q;
	logic [RATE_W-1:0]  rate_held_q;
	logic [VOL_W-1:0]   vol_q;

	logic [TALLY_W-1:0] pulses_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [NUM_W-1:0]   rate_num_q;
	logic [NUM_W-1:0]   vol_num_q;
	logic [K60_W-1:0]   k60_q;

	logic               out_valid_q;
	logic               updated_q;
	logic [RATE_W-1:0]  rate_out_q;
	logic [VOL_W-1:0]   vol_out_q;

	logic [TIME_W-1:0]  elapsed;
	logic               due;
	logic               out_free;
	logic               is_pulse;
	logic               load_out;
	logic               div_start;
	logic               rate_done;
	logic               vol_done;
	logic               div_done;
	logic [NUM_W-1:0]   rate_quo;
	logic [NUM_W-1:0]   vol_quo;
	logic [DEN_W-1:0]   rate_den;
	logic [DEN_W-1:0]   vol_den;
	logic [K_W-1:0]     k_eff;
	logic [VOLMS_W-1:0] vol_ms;
	logic [VOL_W:0]     vol_sum;
	logic [RATE_W-1:0]  rate_new;
	logic [VOL_W-1:0]   vol_new;

	// Classify the head request against the interval
	assign elapsed  = q_item.now_ms - last_q;
	assign due      = (elapsed != '0) && (elapsed >= TIME_W'(cfg.min_interval_ms));
	assign is_pulse = (q_item.kind == KIND_PULSE);
	assign out_free = !out_valid_q || !result_stall;

	assign q_pop = (state_q == ST_IDLE) && q_valid && (is_pulse || due || out_free);

	// Load the result register on an early read or at the end of an update
	assign load_out = ((state_q == ST_IDLE) && q_valid && !is_pulse && !due && out_free)
		|| ((state_q == ST_EMIT) && out_free);

	// Scale products
	assign k_eff    = (cfg.pulses_per_lpm == '0) ? K_W'(1) : cfg.pulses_per_lpm;
	assign vol_ms   = VOLMS_W'(pulses_q) * VOLMS_W'(VOL_MUL);
	assign rate_den = DEN_W'(k60_q) * DEN_W'(elapsed_q);
	assign vol_den  = DEN_W'(k60_q);

	assign div_start = (state_q == ST_DEN);
	assign div_done  = rate_done && vol_done;

	prfm_div u_rate_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rate_num_q),
		.den    (rate_den),
		.done   (rate_done),
		.quo    (rate_quo)
	);

	prfm_div u_vol_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (vol_num_q),
		.den    (vol_den),
		.done   (vol_done),
		.quo    (vol_quo)
	);

	// Saturate rate and volume
	assign vol_sum  = {1'b0, vol_q} + {1'b0, vol_quo[VOL_W-1:0]};
	assign rate_new = (|rate_quo[NUM_W-1:RATE_W]) ? '1 : rate_quo[RATE_W-1:0];
	assign vol_new  = ((|vol_quo[NUM_W-1:VOL_W]) || vol_sum[VOL_W]) ? '1 : vol_sum[VOL_W-1:0];

	// Work registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && q_valid && !is_pulse && due) begin
			pulses_q  <= tally_q;
			elapsed_q <= elapsed;
		end
		if (state_q == ST_MUL) begin
			rate_num_q <= NUM_W'(pulses_q) * NUM_W'(RATE_NUM);
			vol_num_q  <= {{(NUM_W - VOLMS_W - FRAC_W){1'b0}}, vol_ms, {FRAC_W{1'b0}}};
			k60_q      <= K60_W'(k_eff) * K60_W'(PER_MIN);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_EMIT) begin
				updated_q  <= 1'b1;
				rate_out_q <= rate_new;
				vol_out_q  <= vol_new;
			end else begin
				updated_q  <= 1'b0;
				rate_out_q <= rate_held_q;
				vol_out_q  <= vol_q;
			end
		end
	end

	// Sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			last_q      <= '0;
			rate_held_q <= '0;
			vol_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (is_pulse) begin
							if (tally_q != '1) begin
								tally_q <= tally_q + 1'b1;
							end
						end else if (due) begin
							tally_q <= '0;
							last_q  <= q_item.now_ms;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						rate_held_q <= rate_new;
						vol_q       <= vol_new;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign updated      = updated_q;
	assign rate_q8      = rate_out_q;
	assign volume_q16   = vol_out_q;

	always_comb begin
		status.state    = state_q;
		status.div_done = div_done;
		status.load_out = load_out;
	end

endmodule

// ===== rtl/pulse_flow_rate_meter_core.sv =====
`timescale 1ns / 1ps
// Top level of the pulse flow rate meter: configuration registers, front and back ends.
// Depends on prfm_pkg, prfm_front, prfm_back.
//
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// item     | item_valid / item_stall   | mode, now_ms
// result   | result_valid / result_stall | updated, rate_q8, volume_q16
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A pulse request is popped and tallied once it reaches the queue head while the back end is idle.
// A read that updates holds the back end through the pop, the multiply and denominator setup states,
// the steps of the two radix-2 dividers side by side, the wait for done and the emit.
// A read that comes too early is answered with the held values once the result register is free.
// The queue accepts requests while the back end works; item_stall rises only when full.
// Reset clears the tally, timestamp, held rate, volume and queue; cfg_ready is always high.
module pulse_flow_rate_meter_core import prfm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  mode,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  updated,
	output logic [RATE_W-1:0]     rate_q8,
	output logic [VOL_W-1:0]      volume_q16,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t         cfg_q;
	logic         q_valid;
	item_t        q_item;
	logic         q_pop;
	back_status_t bst;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_ms <= MIN_INTERVAL_RST;
			cfg_q.pulses_per_lpm  <= K_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_INTERVAL:   cfg_q.min_interval_ms <= cfg_data[MIN_W-1:0];
				CFG_PULSES_PER_LPM: cfg_q.pulses_per_lpm  <= cfg_data[K_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	prfm_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.now_ms     (now_ms),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	prfm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.updated      (updated),
		.rate_q8      (rate_q8),
		.volume_q16   (volume_q16),
		.status       (bst)
	);

`ifndef SYNTHESIS
	// Pop only a queue that holds a request
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// Divider completes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		bst.div_done |-> (bst.state == ST_DIV))
		else $error("divider done outside divide state");

	// Never overwrite a result that is still stalled
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		bst.load_out |-> !(result_valid && result_stall))
		else $error("result register overwritten while stalled");

	// A loaded result is presented in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		bst.load_out |=> result_valid)
		else $error("loaded result not presented");
`endif

endmodule
